FILE: rtl/sgm_pkg.sv
package sgm_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;
  localparam int unsigned RegIdxW      = 1;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned WidthRegW    = 11;
  localparam int unsigned HeightRegW   = 13;
  localparam int unsigned PixW         = 8;
  localparam int unsigned SumW         = 21;
  localparam int unsigned RootSteps    = 8;
  localparam int unsigned MagLimit     = 255;

  localparam logic [RegIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [RegIdxW-1:0] RegHeight = 1'b1;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic            vld;
    logic [SumW-1:0] rem;
    logic [7:0]      root;
    logic            sat;
    logic [11:0]     row;
    logic [9:0]      col;
    logic            last;
  } root_lane_t;

endpackage

FILE: rtl/sgm_root_cell.sv
// One restoring square-root step: decides a single result bit.
module sgm_root_cell import sgm_pkg::*; #(
  parameter int unsigned Bit = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  root_lane_t lane_i,
  output root_lane_t lane_o
);

  logic [7:0]      trial;
  logic [SumW-1:0] sq;
  root_lane_t      lane_d, lane_q;

  // (m | b)^2 = m^2 + 2*m*b + b^2; rem holds s - m^2, so compare against 2*m*b + b^2.
  always_comb begin
    trial = lane_i.root | (8'd1 << Bit);
    sq    = (SumW'(lane_i.root) << (Bit + 1)) + (SumW'(1) << (2 * Bit));
    lane_d = lane_i;
    if (lane_i.rem >= sq) begin
      lane_d.rem  = lane_i.rem - sq;
      lane_d.root = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: rtl/sgm_window.sv
// Line stores, 3x3 window, counters and the Sobel sums (two register stages).
module sgm_window import sgm_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  take_i,
  input  logic [PixW-1:0]       pixel_i,
  input  logic [WidthRegW-1:0]  width_i,
  input  logic [HeightRegW-1:0] height_i,
  output root_lane_t            lane_o
);

  localparam int unsigned ColW = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
  localparam int unsigned RowW = $clog2(MaxHeight);

  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];

  logic [ColW:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] win_q [9];
  logic            s1_vld_q, s1_last_q;
  logic [PixW-1:0] s1_px_q;
  logic [11:0]     s1_row_q;
  logic [9:0]      s1_col_q;
  logic            s1_uok_q, s1_mok_q;
  logic [PixW-1:0] up_rd_q, mid_rd_q;
  // Marks that stage one holds an accepted item, result or not.
  logic            s1_mv_q;

  logic [31:0] w_use, h_use;
  logic        in_range, line_end, last_line;

  always_comb begin
    w_use = 32'(width_i);
    if (w_use < 32'd3) w_use = 32'd3;
    if (w_use > 32'(MaxWidth)) w_use = 32'(MaxWidth);
    h_use = 32'(height_i);
    if (h_use < 32'd3) h_use = 32'd3;
    if (h_use > 32'(MaxHeight)) h_use = 32'(MaxHeight);
    in_range  = 32'(col_q) < 32'(MaxWidth);
    line_end  = 32'(col_q) + 32'd1 >= w_use;
    last_line = 32'(row_q) + 32'd1 >= h_use;
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (line_end) begin
      col_d = '0;
      row_d = last_line ? '0 : row_q + 1'b1;
    end
  end

  // Stage one: read the line stores, write them back; stage two uses the data.
  always_ff @(posedge clk_i) begin
    if (take_i && in_range) begin
      up_rd_q  <= upper_mem[col_q[ColW-1:0]];
      mid_rd_q <= middle_mem[col_q[ColW-1:0]];
      upper_mem[col_q[ColW-1:0]]  <= middle_mem[col_q[ColW-1:0]];
      middle_mem[col_q[ColW-1:0]] <= pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s1_px_q   <= '0;
      s1_row_q  <= '0;
      s1_col_q  <= '0;
      s1_uok_q  <= 1'b0;
      s1_mok_q  <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      if (take_i) begin
        col_q     <= col_d;
        row_q     <= row_d;
        s1_uok_q  <= in_range && (row_q >= RowW'(2));
        s1_mok_q  <= in_range && (row_q >= RowW'(1));
        s1_px_q   <= pixel_i;
        s1_vld_q  <= (row_q >= RowW'(2)) && (col_q >= (ColW + 1)'(2));
        s1_row_q  <= 12'(row_q - 1'b1);
        s1_col_q  <= 10'(col_q - 1'b1);
        s1_last_q <= line_end && last_line;
      end else if (en_i) begin
        s1_vld_q <= 1'b0;
      end
      // The window shifts when the stage-one item moves on.
      if (en_i && s1_mv_q) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k*3]   <= win_q[k*3+1];
          win_q[k*3+1] <= win_q[k*3+2];
        end
        win_q[2] <= s1_uok_q ? up_rd_q : '0;
        win_q[5] <= s1_mok_q ? mid_rd_q : '0;
        win_q[8] <= s1_px_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mv_q <= 1'b0;
    end else if (take_i) begin
      s1_mv_q <= 1'b1;
    end else if (en_i) begin
      s1_mv_q <= 1'b0;
    end
  end

  // Stage two: the window after the shift, then gx^2 + gy^2.
  logic [PixW-1:0]   nw [9];
  logic signed [11:0] gx, gy;
  logic [SumW-1:0]   sum;
  root_lane_t        lane_d, lane_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k*3]   = win_q[k*3+1];
      nw[k*3+1] = win_q[k*3+2];
    end
    nw[2] = s1_uok_q ? up_rd_q : '0;
    nw[5] = s1_mok_q ? mid_rd_q : '0;
    nw[8] = s1_px_q;
    gx = 12'(signed'({4'd0, nw[2]})) + 12'(signed'({3'd0, nw[5], 1'b0}))
       + 12'(signed'({4'd0, nw[8]})) - 12'(signed'({4'd0, nw[0]}))
       - 12'(signed'({3'd0, nw[3], 1'b0})) - 12'(signed'({4'd0, nw[6]}));
    gy = 12'(signed'({4'd0, nw[6]})) + 12'(signed'({3'd0, nw[7], 1'b0}))
       + 12'(signed'({4'd0, nw[8]})) - 12'(signed'({4'd0, nw[0]}))
       - 12'(signed'({3'd0, nw[1], 1'b0})) - 12'(signed'({4'd0, nw[2]}));
    sum = SumW'(24'(gx * gx)) + SumW'(24'(gy * gy));
    lane_d.vld  = s1_vld_q && s1_mv_q;
    lane_d.sat  = sum >= SumW'(65536);
    lane_d.rem  = sum;
    lane_d.root = '0;
    lane_d.row  = s1_row_q;
    lane_d.col  = s1_col_q;
    lane_d.last = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: rtl/sobel_gradient_magnitude_core.sv
// Throughput: one pixel per cycle while the output is not stalled; the whole pipeline (line-store read,
// window, gradient sums, eight root cells, output register) advances together.
// Reset: asynchronous, active low; counters, window and valid flags clear, registers
// return to width 640 and height 480. Line stores are not cleared.
module sobel_gradient_magnitude_core import sgm_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // pixel[7:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // magnitude[7:0], center_row[19:8], center_col[29:20]
  output logic                m_axis_tlast    // frame_end
);

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  en, take;
  root_lane_t            lanes [RootSteps+1];
  logic                  out_vld_q;
  logic [29:0]           out_data_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(640);
      height_q <= HeightRegW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_data_i[WidthRegW-1:0];
        RegHeight: height_q <= cfg_data_i[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  // The pipe moves whenever the output register is free or being emptied.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign take          = s_axis_tvalid && en;

  sgm_window #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_window (
    .clk_i, .rst_ni, .en_i(en), .take_i(take), .pixel_i(s_axis_tdata),
    .width_i(width_q), .height_i(height_q), .lane_o(lanes[0])
  );

  for (genvar g = 0; g < RootSteps; g++) begin : g_cell
    sgm_root_cell #(.Bit(RootSteps - 1 - g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .lane_i(lanes[g]), .lane_o(lanes[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
    end else if (en) begin
      out_vld_q  <= lanes[RootSteps].vld;
      out_data_q <= {lanes[RootSteps].col, lanes[RootSteps].row,
                     lanes[RootSteps].sat ? 8'(MagLimit) : lanes[RootSteps].root};
      out_last_q <= lanes[RootSteps].last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import sgm_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 30;

  typedef struct {
    logic [7:0]  mag;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } grad_t;

  typedef struct {
    logic [7:0] pix;
    bit         typed;
    logic [7:0] mag;
  } pixel_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // pixel[7:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;   // magnitude[7:0], center_row[19:8], center_col[29:20]
  logic                m_axis_tlast;   // frame_end

  sobel_gradient_magnitude_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Predictor state.
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic [7:0]            upper_line[DefMaxWidth];
  logic [7:0]            middle_line[DefMaxWidth];
  int                    win[9];
  int unsigned           col_cnt;
  int unsigned           row_cnt;

  grad_t       grad_q[$];
  int          errors;
  bit          idle_on;
  int unsigned quiet_cycles;
  int unsigned random_items;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_pixel(input logic [7:0] px, input bit typed, input logic [7:0] mag);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          gx;
    int          gy;
    int unsigned sq;
    int unsigned root;
    int unsigned trial;
    bit          line_end;
    bit          last_line;
    logic [7:0]  up;
    logic [7:0]  mid;
    grad_t       g;
    w = clamp_to(width_reg, 3, DefMaxWidth);
    h = clamp_to(height_reg, 3, DefMaxHeight);
    c = col_cnt;
    r = row_cnt;
    line_end = (c + 1 >= w);
    last_line = (r + 1 >= h);
    up = '0;
    mid = '0;
    if (c < DefMaxWidth && r >= 2) up = upper_line[c];
    if (c < DefMaxWidth && r >= 1) mid = middle_line[c];
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    if (c < DefMaxWidth) begin
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
    end
    if (r >= 2 && c >= 2) begin
      gx = -win[0] + win[2] - 2*win[3] + 2*win[5] - win[6] + win[8];
      gy = -win[0] - 2*win[1] - win[2] + win[6] + 2*win[7] + win[8];
      sq = gx*gx + gy*gy;
      root = 0;
      if (sq >= 65536) begin
        root = MagLimit;
      end else begin
        for (int unsigned b = 128; b != 0; b = b >> 1) begin
          trial = root | b;
          if (trial*trial <= sq) root = trial;
        end
      end
      g.mag  = typed ? mag : root[7:0];
      g.row  = 12'(r - 1);
      g.col  = 10'(c - 1);
      g.last = line_end && last_line;
      grad_q.push_back(g);
    end
    if (line_end) begin
      col_cnt = 0;
      row_cnt = last_line ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic send_pixel(input logic [7:0] px, input bit typed, input logic [7:0] mag);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
      @(negedge clk_i);
    end
    predict_pixel(px, typed, mag);
    @(negedge clk_i);
  endtask

  // Waits for all results and for the pipeline to empty, then writes a register.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid <= 1'b0;
    wait (grad_q.size() == 0);
    @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == RegWidth) width_reg = val[WidthRegW-1:0];
    else height_reg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frames(input int unsigned frames, input bit count_random);
    int unsigned npix;
    int unsigned mode;
    int          base;
    logic [7:0]  px;
    npix = frames * clamp_to(width_reg, 3, DefMaxWidth) * clamp_to(height_reg, 3, DefMaxHeight);
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < npix; i++) begin
      case (mode)
        0: begin
          px = 8'($urandom_range(0, 255));
        end
        1: begin
          px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          base = base + $urandom_range(0, 16) - 8;
          if (base < 0) base = 0;
          if (base > 255) base = 255;
          px = base[7:0];
        end
      endcase
      send_pixel(px, 1'b0, '0);
      if (count_random) random_items++;
    end
  endtask

  // Three 3x3 frames: flat, a sharp vertical edge, and a gentle ramp.
  pixel_row_t directed[27] = '{
    '{8'd0, 0, 0}, '{8'd0, 0, 0}, '{8'd0, 0, 0},
    '{8'd0, 0, 0}, '{8'd0, 0, 0}, '{8'd0, 0, 0},
    '{8'd0, 0, 0}, '{8'd0, 0, 0}, '{8'd0, 1, 8'd0},
    '{8'd0, 0, 0}, '{8'd255, 0, 0}, '{8'd255, 0, 0},
    '{8'd0, 0, 0}, '{8'd255, 0, 0}, '{8'd255, 0, 0},
    '{8'd0, 0, 0}, '{8'd255, 0, 0}, '{8'd255, 1, 8'd255},
    '{8'd10, 0, 0}, '{8'd20, 0, 0}, '{8'd40, 0, 0},
    '{8'd15, 0, 0}, '{8'd30, 0, 0}, '{8'd60, 0, 0},
    '{8'd20, 0, 0}, '{8'd50, 0, 0}, '{8'd128, 0, 0}
  };

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result checker with its own random back-pressure.
  initial begin
    grad_t       g;
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (m_axis_tvalid) break;
      end
      if (grad_q.size() == 0) begin
        $error("unexpected result: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        g = grad_q.pop_front();
        if (m_axis_tdata[7:0] !== g.mag) begin
          $error("magnitude: expected %0d, actual %0d", g.mag, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[19:8] !== g.row) begin
          $error("center_row: expected %0d, actual %0d", g.row, m_axis_tdata[19:8]);
          errors++;
        end
        if (m_axis_tdata[29:20] !== g.col) begin
          $error("center_col: expected %0d, actual %0d", g.col, m_axis_tdata[29:20]);
          errors++;
        end
        if (m_axis_tlast !== g.last) begin
          $error("frame_end: expected %0d, actual %0d", g.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    errors        = 0;
    quiet_cycles  = 0;
    random_items  = 0;
    idle_on       = 1'b1;
    width_reg     = 11'd640;
    height_reg    = 13'd480;
    col_cnt       = 0;
    row_cnt       = 0;
    foreach (win[k]) win[k] = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegWidth;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegWidth, 13'd3);
    write_reg(RegHeight, 13'd3);
    foreach (directed[i]) send_pixel(directed[i].pix, directed[i].typed, directed[i].mag);

    // Values below the minimum clamp up to a 3x3 frame.
    write_reg(RegWidth, 13'd0);
    write_reg(RegHeight, 13'd0);
    send_frames(2, 1'b0);

    while (random_items < 1700) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(RegWidth, 13'($urandom_range(0, 7) == 0 ? $urandom_range(0, 3)
                                                        : $urandom_range(3, 16)));
      write_reg(RegHeight, 13'($urandom_range(3, 10)));
      send_frames($urandom_range(1, 2), 1'b1);
    end

    s_axis_tvalid <= 1'b0;
    wait (grad_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
